FILE: design/mbp_pkg.sv
package mbp_pkg;

    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int CNT_W      = 3;
    localparam int ACC_W      = CODE_W + BYTE_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0] MAX_CODE_LEN = 6'd32;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // One queued command: up to four finished bytes, right-justified in word,
    // emitted from byte index idx down to byte zero.
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [1:0]        idx;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
    } t_queue_wr;

    typedef struct packed {
        logic pop;
        logic valid;
    } t_queue_rd;

endpackage

FILE: design/mbp_in_if.sv
interface mbp_in_if
    import mbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, output operation, output code_value,
                    output code_length, input ready);
    modport sink   (input valid, input operation, input code_value,
                    input code_length, output ready);
endinterface

FILE: design/mbp_out_if.sv
interface mbp_out_if
    import mbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: design/mbp_front.sv
module mbp_front
    import mbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbp_in_if.sink     i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [BYTE_W-1:0] r_partial, n_partial;
    logic [CNT_W-1:0]  r_count, n_count;

    logic [LEN_W-1:0]  len;
    logic [ACC_W-1:0]  masked_val;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  shifted;
    logic [LEN_W-1:0]  total;
    logic [2:0]        rem;
    logic [2:0]        nbytes;
    logic              accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        len        = (i_in.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : i_in.code_length;
        masked_val = {{BYTE_W{1'b0}}, i_in.code_value} & ~({ACC_W{1'b1}} << len);
        acc        = ({{CODE_W{1'b0}}, r_partial} << len) | masked_val;
        total      = {{(LEN_W-CNT_W){1'b0}}, r_count} + len;
        rem        = total[2:0];
        nbytes     = total[5:3];
        shifted    = acc >> rem;

        n_partial = r_partial;
        n_count   = r_count;
        o_push    = 1'b0;
        o_cmd     = '{word: shifted[CODE_W-1:0], idx: 2'(nbytes - 3'd1)};

        if (accept) begin
            if (i_in.operation == OP_FLUSH) begin
                o_push    = (r_count != '0);
                o_cmd     = '{word: {{(CODE_W-BYTE_W){1'b0}}, r_partial}, idx: 2'd0};
                n_partial = '0;
                n_count   = '0;
            end else begin
                o_push    = (nbytes != 3'd0);
                n_partial = acc[BYTE_W-1:0] & ~({BYTE_W{1'b1}} << rem);
                n_count   = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_count   <= '0;
        end else begin
            r_partial <= n_partial;
            r_count   <= n_count;
        end
    end

endmodule

FILE: design/mbp_queue.sv
module mbp_queue
    import mbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    output t_queue_wr o_wr,
    input  logic      i_pop,
    output t_queue_rd o_rd,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push;
    logic       do_pop;

    always_comb begin
        o_wr.full  = (r_cnt == 2'(QUEUE_DEPTH));
        o_wr.push  = i_push;
        o_rd.valid = (r_cnt != 2'd0);
        o_rd.pop   = i_pop;
        o_cmd      = r_mem[r_rd_ptr];

        do_push  = i_push && !o_wr.full;
        do_pop   = i_pop && o_rd.valid;
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

FILE: design/mbp_back.sv
module mbp_back
    import mbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_pop,
    mbp_out_if.source o_out
);

    logic              r_cmd_valid, n_cmd_valid;
    logic [CODE_W-1:0] r_word, n_word;
    logic [1:0]        r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              adv;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    always_comb begin
        // A byte moves into the output register whenever it is empty or drains.
        adv   = r_cmd_valid && (!r_out_valid || o_out.ready);
        o_pop = i_q_valid && (!r_cmd_valid || (adv && r_idx == 2'd0));

        n_cmd_valid = r_cmd_valid;
        n_word      = r_word;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (adv) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_word[BYTE_W*r_idx +: BYTE_W];
            n_out_last  = (r_idx == 2'd0);
            n_idx       = r_idx - 2'd1;
            if (r_idx == 2'd0) begin
                n_cmd_valid = 1'b0;
            end
        end

        if (o_pop) begin
            n_cmd_valid = 1'b1;
            n_word      = i_q_cmd.word;
            n_idx       = i_q_cmd.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_idx      <= n_idx;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd_valid <= n_cmd_valid;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/msb_first_bit_packer.sv
// A word's first byte passes through the command queue and the back end's command and
// output registers. An append gives up to four bytes, one byte per cycle while the
// byte output port is ready; the byte output port sets the pace.
// A two-entry command queue lets the front accept words while bytes drain.
// Reset (synchronous, active low) clears the pending bits, the queue and the output.
module msb_first_bit_packer
    import mbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbp_in_if.sink    i_in,
    mbp_out_if.source o_out
);

    t_cmd      front_cmd;
    t_cmd      q_cmd;
    logic      push;
    logic      pop;
    t_queue_wr q_wr;
    t_queue_rd q_rd;

    mbp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_wr.full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    mbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_wr    (q_wr),
        .i_pop   (pop),
        .o_rd    (q_rd),
        .o_cmd   (q_cmd)
    );

    mbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_rd.valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: tb/msb_first_bit_packer_test.sv
`timescale 1ns / 1ps

module msb_first_bit_packer_test;
    import mbp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_packed_byte;

    // Mirrors the packer: pending bits plus the bytes each word should produce.
    class packer_scoreboard;
        logic [BYTE_W-1:0] held_bits;
        logic [CNT_W-1:0]  held_count;
        t_packed_byte      due_bytes[$];
        int                errors;

        function new();
            held_bits  = '0;
            held_count = '0;
            errors     = 0;
        endfunction

        function void pack_word(logic op, logic [CODE_W-1:0] value,
                                logic [LEN_W-1:0] len);
            logic [ACC_W-1:0] acc;
            logic [ACC_W-1:0] mask;
            logic [ACC_W-1:0] shifted;
            t_packed_byte     entry;
            int               n;
            int               total;
            if (op == OP_FLUSH) begin
                if (held_count != 0) begin
                    entry.out_byte = held_bits;
                    entry.last     = 1'b1;
                    due_bytes.push_back(entry);
                end
                held_bits  = '0;
                held_count = '0;
                return;
            end
            n = (len > MAX_CODE_LEN) ? CODE_W : int'(len);
            if (n == 0) begin
                return;
            end
            mask  = (ACC_W'(1) << n) - ACC_W'(1);
            acc   = (ACC_W'(held_bits) << n) | (ACC_W'(value) & mask);
            total = int'(held_count) + n;
            while (total >= BYTE_W) begin
                total          = total - BYTE_W;
                shifted        = acc >> total;
                entry.out_byte = shifted[BYTE_W-1:0];
                entry.last     = (total < BYTE_W);
                due_bytes.push_back(entry);
            end
            mask       = (ACC_W'(1) << total) - ACC_W'(1);
            shifted    = acc & mask;
            held_bits  = shifted[BYTE_W-1:0];
            held_count = total[CNT_W-1:0];
        endfunction

        function void check_byte(logic [BYTE_W-1:0] got_byte, logic got_last);
            t_packed_byte want;
            if (due_bytes.size() == 0) begin
                errors++;
                $display("%0t: expected no word, got out_byte %02h last %0d",
                         $time, got_byte, got_last);
                return;
            end
            want = due_bytes.pop_front();
            if (want.out_byte !== got_byte) begin
                errors++;
                $display("%0t: out_byte expected %02h, got %02h",
                         $time, want.out_byte, got_byte);
            end
            if (want.last !== got_last) begin
                errors++;
                $display("%0t: last expected %0d, got %0d", $time, want.last, got_last);
            end
        endfunction

        function bit drained();
            return due_bytes.size() == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mbp_in_if  in_bus();
    mbp_out_if out_bus();

    msb_first_bit_packer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    packer_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    bit hold_done;
    int cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off when requested.
    initial begin
        out_bus.ready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                sb.pack_word(in_bus.operation, in_bus.code_value, in_bus.code_length);
            end
            if (out_bus.valid && out_bus.ready) begin
                sb.check_byte(out_bus.out_byte, out_bus.last);
            end
        end
    end

    task automatic send_word(logic op, logic [CODE_W-1:0] value, logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid       <= 1'b1;
        in_bus.operation   <= op;
        in_bus.code_value  <= value;
        in_bus.code_length <= len;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic send_random_word(int min_len);
        logic [CODE_W-1:0] value;
        logic [LEN_W-1:0]  len;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            len = '0;
        end else if (pick < 10) begin
            len = LEN_W'($urandom_range(63, 33));
        end else if (pick < 30) begin
            len = LEN_W'($urandom_range(32, 25));
        end else begin
            len = LEN_W'($urandom_range(24, 1));
        end
        if (int'(len) < min_len) begin
            len = LEN_W'(min_len);
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            value = '1;
        end else if (pick == 1) begin
            value = '0;
        end else begin
            value = $urandom;
        end
        if (min_len == 0 && $urandom_range(99) < 12) begin
            send_word(OP_FLUSH, value, len);
        end else begin
            send_word(OP_APPEND, value, len);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_word(0);
    endtask

    initial begin
        sb                 = new();
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_request       = 1'b0;
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.operation   = OP_APPEND;
        in_bus.code_value  = '0;
        in_bus.code_length = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Corner cases: empty flush, zero length, saturated length, masked high bits,
        // flushes on and off a byte boundary.
        send_word(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_word(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
        send_word(OP_FLUSH,  32'hFFFF_FFFF, 6'd63);
        send_word(OP_APPEND, 32'hFFFF_FFFF, 6'd32);
        send_word(OP_APPEND, 32'h0000_0000, 6'd32);
        send_word(OP_APPEND, 32'hFFFF_FFFF, 6'd1);
        send_word(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_word(OP_APPEND, 32'hFFFF_FF55, 6'd7);
        send_word(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_word(OP_APPEND, 32'hFFFF_FFA5, 6'd8);
        send_word(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_word(OP_APPEND, 32'h1234_5678, 6'd63);
        send_word(OP_APPEND, 32'h8765_4321, 6'd33);
        send_word(OP_APPEND, 32'hFFFF_FFFA, 6'd3);
        send_word(OP_APPEND, 32'h8000_0001, 6'd32);
        send_word(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_word(OP_APPEND, 32'hFFFF_FFEA, 6'd5);
        send_word(OP_APPEND, 32'hFFFF_FFF5, 6'd3);
        send_word(OP_FLUSH,  32'h0000_0000, 6'd0);
        send_word(OP_APPEND, 32'hAAAA_AAAA, 6'd31);
        send_word(OP_APPEND, 32'h5555_5555, 6'd16);
        send_word(OP_FLUSH,  32'h0000_0000, 6'd0);

        run_phase(0, 0, 110);
        run_phase(59, 0, 110);
        run_phase(0, 59, 110);
        run_phase(16, 16, 110);

        // Long receiver hold-off while long codes keep coming, so the block backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        repeat (40) send_random_word(24);
        send_word(OP_FLUSH, 32'h0000_0000, 6'd0);
        @(negedge i_clk);
        in_bus.valid <= 1'b0;

        while (!sb.drained()) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!sb.drained()) begin
            sb.errors++;
            $display("%0t: %0d expected words never arrived", $time, sb.due_bytes.size());
        end
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
